[rtl/tsdf_pkg.sv]
package tsdf_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 2;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_NUMBER_MODE      = 3'd0,
      CSR_SQUEEZE_BLANK    = 3'd1,
      CSR_SHOW_ENDS        = 3'd2,
      CSR_SHOW_TABS        = 3'd3,
      CSR_SHOW_NONPRINTING = 3'd4
   } csr_index_type;

   localparam logic [1:0] NUMBER_ALL = 2'd1;

   localparam logic [7:0] CHAR_TAB    = 8'h09;
   localparam logic [7:0] CHAR_NL     = 8'h0A;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_DASH   = 8'h2D;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_QMARK  = 8'h3F;
   localparam logic [7:0] CHAR_CARET  = 8'h5E;
   localparam logic [7:0] CHAR_I      = 8'h49;
   localparam logic [7:0] CHAR_M      = 8'h4D;
   localparam logic [6:0] CHAR_DEL    = 7'h7F;
   localparam logic [7:0] CARET_BIAS  = 8'h40;

   localparam logic [23:0] BCD_ONE = 24'h000001;
   localparam logic [23:0] BCD_MAX = 24'h999999;

   // burst slots: six digits, tab, dollar, up to four body bytes
   localparam logic [3:0] SLOT_TAB    = 4'd6;
   localparam logic [3:0] SLOT_DOLLAR = 4'd7;
   localparam logic [3:0] SLOT_BODY   = 4'd8;

   typedef struct packed {
      logic [1:0] number_mode;
      logic       squeeze_blank;
      logic       show_ends;
      logic       show_tabs;
      logic       show_nonprinting;
   } cfg_type;

   typedef struct packed {
      logic            num_en;
      logic [23:0]     num;
      logic            dollar;
      logic [3:0][7:0] body;
      logic [1:0]      body_last;
   } desc_type;

   function automatic logic [23:0] bcd_inc(input logic [23:0] v);
      logic [23:0] r;
      logic        carry;
      logic [4:0]  d;
      r = '0;
      carry = 1'b1;
      if (v >= BCD_MAX) begin
         r = BCD_MAX;
      end else begin
         for (int i = 0; i < 6; i++) begin
            d = {1'b0, v[4*i +: 4]} + {4'd0, carry};
            if (d > 5'd9) begin
               d = '0;
               carry = 1'b1;
            end else begin
               carry = 1'b0;
            end
            r[4*i +: 4] = d[3:0];
         end
      end
      return r;
   endfunction

endpackage

[rtl/text_stream_display_filter_unit.sv]
// Text display filter: each byte pushed in yields a burst of zero to eleven bytes on the
// result side (optional six-digit line number and tab, optional '$' before a newline, the
// byte itself or its ^X / ^? / M- / ^I escape), with burst_last set on the final byte of
// each burst; squeezed repeat blank lines yield nothing. The front stage classifies one
// byte per cycle while the queue has room and updates the line state; the back stage
// writes one output byte per cycle while a burst is queued and the output is free, so a
// byte holds the back stage for as long as its burst is long (a dropped blank line only
// costs its accept in the front), and the sustained rate is set by the back stage's
// single output byte per cycle. A queue of QUEUE_DEPTH bursts sits between the two.
// Configuration writes take effect at once and should be made while the block is idle.
module text_stream_display_filter_unit #(
   parameter int QUEUE_DEPTH = tsdf_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_push,
   output logic                           req_full,
   input  logic [7:0]                     req_in_byte,
   output logic                           rsp_empty,
   input  logic                           rsp_pop,
   output logic [7:0]                     rsp_out_byte,
   output logic                           rsp_burst_last,
   input  logic                           csr_write_en,
   input  logic [tsdf_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [tsdf_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import tsdf_pkg::*;

   cfg_type  cfg_ff, cfg_in;
   logic     q_push;
   logic     q_pop;
   logic     q_full;
   logic     q_empty;
   desc_type q_data;
   desc_type q_head;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_NUMBER_MODE:      cfg_in.number_mode      = csr_wdata;
            CSR_SQUEEZE_BLANK:    cfg_in.squeeze_blank    = csr_wdata[0];
            CSR_SHOW_ENDS:        cfg_in.show_ends        = csr_wdata[0];
            CSR_SHOW_TABS:        cfg_in.show_tabs        = csr_wdata[0];
            CSR_SHOW_NONPRINTING: cfg_in.show_nonprinting = csr_wdata[0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_full = q_full;

   tsdf_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_push    (req_push),
      .req_in_byte (req_in_byte),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_data      (q_data)
   );

   tsdf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_data),
      .pop       (q_pop),
      .full      (q_full),
      .empty     (q_empty),
      .head      (q_head)
   );

   tsdf_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_empty        (q_empty),
      .q_head         (q_head),
      .q_pop          (q_pop),
      .rsp_pop        (rsp_pop),
      .rsp_empty      (rsp_empty),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_burst_last (rsp_burst_last)
   );

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("burst queue written while full");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("burst queue read while empty");

   a_burst_continues: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_pop && !rsp_burst_last) |=> !rsp_empty)
      else $error("gap inside an output burst");

endmodule

[rtl/tsdf_front.sv]
module tsdf_front (
   input  logic               clock,
   input  logic               reset,
   input  tsdf_pkg::cfg_type  cfg,
   input  logic               req_push,
   input  logic [7:0]         req_in_byte,
   input  logic               q_full,
   output logic               q_push,
   output tsdf_pkg::desc_type q_data
);
   import tsdf_pkg::*;

   logic [23:0] line_count_ff, line_count_in;
   logic        at_line_start_ff, at_line_start_in;
   logic        prev_line_empty_ff, prev_line_empty_in;

   logic            accept;
   logic            nl;
   logic            tab;
   logic            drop;
   logic            num_en;
   logic [6:0]      lo;
   logic [7:0]      lo_caret;
   logic            lo_ctrl;
   logic [3:0][7:0] body;
   logic [1:0]      body_last;

   assign accept = req_push && !q_full;
   assign nl     = (req_in_byte == CHAR_NL);
   assign tab    = (req_in_byte == CHAR_TAB);
   assign drop   = cfg.squeeze_blank && nl && at_line_start_ff && prev_line_empty_ff;
   assign num_en = at_line_start_ff &&
                   ((cfg.number_mode == NUMBER_ALL) || (cfg.number_mode[1] && !nl));

   assign lo       = req_in_byte[6:0];
   assign lo_ctrl  = (lo[6:5] == 2'b00) || (lo == CHAR_DEL);
   assign lo_caret = (lo == CHAR_DEL) ? CHAR_QMARK : ({3'b000, lo[4:0]} | CARET_BIAS);

   always_comb begin
      body      = '0;
      body_last = 2'd0;
      body[0]   = req_in_byte;
      if (cfg.show_nonprinting && !nl && !tab && req_in_byte[7]) begin
         body[0] = CHAR_M;
         body[1] = CHAR_DASH;
         if (lo_ctrl) begin
            body[2]   = CHAR_CARET;
            body[3]   = lo_caret;
            body_last = 2'd3;
         end else begin
            body[2]   = {1'b0, lo};
            body_last = 2'd2;
         end
      end else if (cfg.show_nonprinting && !nl && !tab && lo_ctrl) begin
         body[0]   = CHAR_CARET;
         body[1]   = lo_caret;
         body_last = 2'd1;
      end else if (cfg.show_tabs && tab) begin
         body[0]   = CHAR_CARET;
         body[1]   = CHAR_I;
         body_last = 2'd1;
      end
   end

   assign q_push           = accept && !drop;
   assign q_data.num_en    = num_en;
   assign q_data.num       = line_count_ff;
   assign q_data.dollar    = cfg.show_ends && nl;
   assign q_data.body      = body;
   assign q_data.body_last = body_last;

   always_comb begin
      line_count_in      = line_count_ff;
      at_line_start_in   = at_line_start_ff;
      prev_line_empty_in = prev_line_empty_ff;
      if (q_push) begin
         prev_line_empty_in = nl && at_line_start_ff;
         at_line_start_in   = nl;
         if (num_en) begin
            line_count_in = bcd_inc(line_count_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_count_ff      <= BCD_ONE;
         at_line_start_ff   <= 1'b1;
         prev_line_empty_ff <= 1'b0;
      end else begin
         line_count_ff      <= line_count_in;
         at_line_start_ff   <= at_line_start_in;
         prev_line_empty_ff <= prev_line_empty_in;
      end
   end

endmodule

[rtl/tsdf_queue.sv]
module tsdf_queue #(
   parameter int DEPTH = tsdf_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  tsdf_pkg::desc_type push_data,
   input  logic               pop,
   output logic               full,
   output logic               empty,
   output tsdf_pkg::desc_type head
);
   import tsdf_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   desc_type         mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full  = (count_ff == CNT_FULL);
   assign empty = (count_ff == '0);
   assign head  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[rtl/tsdf_back.sv]
module tsdf_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_empty,
   input  tsdf_pkg::desc_type q_head,
   output logic               q_pop,
   input  logic               rsp_pop,
   output logic               rsp_empty,
   output logic [7:0]         rsp_out_byte,
   output logic               rsp_burst_last
);
   import tsdf_pkg::*;

   logic       active_ff, active_in;
   logic [3:0] pos_ff, pos_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       last_ff, last_in;

   logic       out_free;
   logic       emit;
   logic [3:0] start_pos;
   logic [3:0] cur;
   logic [3:0] next_pos;
   logic       cur_last;
   logic [7:0] cur_byte;
   logic [3:0] dig [6];
   logic       blank [6];
   logic       chain;
   logic [2:0] k;

   assign out_free  = !valid_ff || rsp_pop;
   assign emit      = !q_empty && out_free;
   assign start_pos = q_head.num_en ? 4'd0 : (q_head.dollar ? SLOT_DOLLAR : SLOT_BODY);
   assign cur       = active_ff ? pos_ff : start_pos;
   assign cur_last  = (cur >= SLOT_BODY) && (cur[1:0] == q_head.body_last);
   assign next_pos  = (cur == SLOT_TAB) ? (q_head.dollar ? SLOT_DOLLAR : SLOT_BODY)
                                        : cur + 4'd1;
   assign k         = 3'd5 - cur[2:0];

   // leading zeros of the line number print as spaces
   always_comb begin
      chain = 1'b1;
      for (int i = 5; i >= 0; i--) begin
         dig[i]   = (q_head.num[4*i +: 4] > 4'd9) ? 4'd9 : q_head.num[4*i +: 4];
         chain    = chain && (dig[i] == 4'd0) && (i != 0);
         blank[i] = chain;
      end
   end

   always_comb begin
      if (cur < SLOT_TAB) begin
         cur_byte = blank[k] ? CHAR_SPACE : (CHAR_ZERO | {4'd0, dig[k]});
      end else if (cur == SLOT_TAB) begin
         cur_byte = CHAR_TAB;
      end else if (cur == SLOT_DOLLAR) begin
         cur_byte = CHAR_DOLLAR;
      end else begin
         cur_byte = q_head.body[cur[1:0]];
      end
   end

   assign q_pop = emit && cur_last;

   always_comb begin
      active_in = active_ff;
      pos_in    = pos_ff;
      valid_in  = valid_ff && !rsp_pop;
      byte_in   = byte_ff;
      last_in   = last_ff;
      if (emit) begin
         valid_in  = 1'b1;
         byte_in   = cur_byte;
         last_in   = cur_last;
         active_in = !cur_last;
         pos_in    = next_pos;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         valid_ff  <= 1'b0;
      end else begin
         active_ff <= active_in;
         valid_ff  <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff  <= pos_in;
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   assign rsp_empty      = !valid_ff;
   assign rsp_out_byte   = byte_ff;
   assign rsp_burst_last = last_ff;

endmodule
